// ===== src/tqps_pkg.sv =====
// ----------------------------------------------------------------------------
// tqps_pkg
// Shared types and codes of the two-queue strict-priority scheduler.
// ----------------------------------------------------------------------------
package tqps_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  // field widths
  localparam int CMD_W     = 2;
  localparam int ID_W      = 16;
  localparam int TIME_W    = 16;
  localparam int OUTCOME_W = 3;
  localparam int CNT_W     = 32;
  localparam int LIMIT_W   = 5;
  localparam int ENTRY_W   = ID_W + TIME_W;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ADMIT_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0] ADMIT_LIMIT_RESET = 5'd16;

  // commands
  localparam logic [CMD_W-1:0] CMD_HIGH_REQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOW_REQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // outcomes
  localparam logic [OUTCOME_W-1:0] OUT_ACCEPTED    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OUT_REFUSED     = 3'd1;
  localparam logic [OUTCOME_W-1:0] OUT_SERVED_HIGH = 3'd2;
  localparam logic [OUTCOME_W-1:0] OUT_SERVED_LOW  = 3'd3;
  localparam logic [OUTCOME_W-1:0] OUT_IDLE        = 3'd4;

  // statistic counter slots
  localparam int CNT_HIGH_REFUSED = 0;
  localparam int CNT_LOW_REFUSED  = 1;
  localparam int CNT_HIGH_SERVED  = 2;
  localparam int CNT_LOW_SERVED   = 3;
  localparam int CNT_IDLE_TICKS   = 4;
  localparam int CNT_HIGH_WAIT    = 5;
  localparam int CNT_LOW_WAIT     = 6;
  localparam int CNT_NUM          = 7;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } st_t;

  // saturating add of a 32-bit counter and a 16-bit increment
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [TIME_W-1:0] v);
    logic [CNT_W:0] s;
    s = {1'b0, c} + {{(CNT_W-TIME_W+1){1'b0}}, v};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ===== src/tqps_ram.sv =====
// ----------------------------------------------------------------------------
// tqps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tqps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/two_queue_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_queue_priority_scheduler
// Strict-priority scheduler over two bounded FIFOs kept in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one command per beat: tuser carries the command
//    (high request, low request, service tick), tdata the id, arrival
//    time and current time.
//  - Master stream returns one result beat per command: tuser holds the
//    outcome, tdata the served id, wait, both occupancies and the seven
//    saturating statistic counters.
//  - A request is settled in the accept cycle: admission, RAM write and
//    counters. A service tick first reads the head entry from the queue
//    RAM (registered read port), and the wait is worked out in the
//    following cycle.
//  - A result stage and an output register sit between the sides, so a
//    command is taken while one finished result waits on the master side.
//    When the receiver stalls, at most one further result is held and
//    tready then drops.
//  - Reset clears heads, tails, counts, counters and sets the limit to 16.
//    Queue RAM contents are not cleared: only written entries are read.
//  - The admission limit lies at APB address 0; pready is always high.
// ----------------------------------------------------------------------------
module two_queue_priority_scheduler #(
  parameter int QUEUE_DEPTH = tqps_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int CW    = $clog2(QUEUE_DEPTH + 1),
  parameter int OUT_W = ((2 * tqps_pkg::TIME_W + 2 * CW
                          + tqps_pkg::CNT_NUM * tqps_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // item_id, arrival_time, current_time
  input  logic [47:0]                     s_tdata,
  // command
  input  logic [tqps_pkg::CMD_W-1:0]      s_tuser,
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // served_id, wait_time, high_occupancy, low_occupancy, high_refused,
  // low_refused, high_served, low_served, idle_ticks, high_wait_sum,
  // low_wait_sum, zero pad
  output logic [OUT_W-1:0]                m_tdata,
  // outcome
  output logic [tqps_pkg::OUTCOME_W-1:0]  m_tuser,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tqps_pkg::PADDR_W-1:0]    paddr,
  input  logic [tqps_pkg::PDATA_W-1:0]    pwdata,
  output logic [tqps_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  import tqps_pkg::*;

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int RAW_W = 2 * TIME_W + 2 * CW + CNT_NUM * CNT_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

  // configuration
  logic [LIMIT_W-1:0] admit_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      admit_limit <= ADMIT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_ADMIT_LIMIT) begin
      admit_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_ADMIT_LIMIT) begin
      prdata = PDATA_W'(admit_limit);
    end
  end

  // input fields
  logic [ID_W-1:0]   in_id;
  logic [TIME_W-1:0] in_arrival;
  logic [TIME_W-1:0] in_now;

  assign in_id      = s_tdata[15:0];
  assign in_arrival = s_tdata[31:16];
  assign in_now     = s_tdata[47:32];

  // queue control state
  st_t            state, state_next;
  logic [AW-1:0]  hhead, htail, lhead, ltail;
  logic [CW-1:0]  hcount, lcount, hcount_next, lcount_next;
  logic           sel_high;
  logic [TIME_W-1:0] now_q;
  logic [CNT_W-1:0] cnt [CNT_NUM];
  logic [CNT_W-1:0] cnt_next [CNT_NUM];

  // result stage and output register
  logic                 res_valid;
  logic [RAW_W-1:0]     res_data;
  logic [OUTCOME_W-1:0] res_user;
  logic                 out_free;

  assign out_free = !m_tvalid || m_tready;

  // handshake decode
  logic accept, is_tick, req_high, do_req, push_ok, pop_start, idle_tick;
  logic res_load;
  logic [LW-1:0] limit_eff, req_count;

  always_comb begin
    s_tready = 1'b0;
    case (state)
      ST_IDLE:  s_tready = !res_valid || out_free;
      ST_FETCH: s_tready = 1'b0;
      default:  s_tready = 1'b0;
    endcase
  end

  assign accept    = s_tvalid && s_tready;
  assign is_tick   = s_tuser[1];
  assign req_high  = (s_tuser == CMD_HIGH_REQ);
  assign do_req    = accept && !is_tick;
  assign limit_eff = (LW'(admit_limit) > DEPTH_L) ? DEPTH_L : LW'(admit_limit);
  assign req_count = req_high ? LW'(hcount) : LW'(lcount);
  assign push_ok   = req_count < limit_eff;
  assign pop_start = accept && is_tick && (hcount != '0 || lcount != '0);
  assign idle_tick = accept && is_tick && hcount == '0 && lcount == '0;
  assign res_load  = do_req || idle_tick || (state == ST_FETCH);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (pop_start) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // queue RAMs: id in the upper half, arrival in the lower
  logic             hwe, lwe, hre, lre;
  logic [ENTRY_W-1:0] hrdata, lrdata, wentry, head_entry;

  assign wentry = {in_id, in_arrival};
  assign hwe    = do_req && push_ok && req_high;
  assign lwe    = do_req && push_ok && !req_high;
  assign hre    = pop_start && hcount != '0;
  assign lre    = pop_start && hcount == '0;

  tqps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_high_ram (
    .clk   (clk),
    .we    (hwe),
    .waddr (htail),
    .wdata (wentry),
    .re    (hre),
    .raddr (hhead),
    .rdata (hrdata)
  );

  tqps_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH), .AW(AW)) u_low_ram (
    .clk   (clk),
    .we    (lwe),
    .waddr (ltail),
    .wdata (wentry),
    .re    (lre),
    .raddr (lhead),
    .rdata (lrdata)
  );

  // served entry and its wait, clamped at zero
  logic [ID_W-1:0]   srv_id;
  logic [TIME_W-1:0] srv_start, srv_wait;

  assign head_entry = sel_high ? hrdata : lrdata;
  assign srv_id     = head_entry[ENTRY_W-1:TIME_W];
  assign srv_start  = head_entry[TIME_W-1:0];
  assign srv_wait   = (now_q >= srv_start) ? (now_q - srv_start) : '0;

  // occupancy
  always_comb begin
    hcount_next = hcount;
    lcount_next = lcount;
    if (hwe) hcount_next = hcount + 1'b1;
    if (lwe) lcount_next = lcount + 1'b1;
    if (hre) hcount_next = hcount - 1'b1;
    if (lre) lcount_next = lcount - 1'b1;
  end

  // statistic counters
  always_comb begin
    for (int k = 0; k < CNT_NUM; k++) begin
      cnt_next[k] = cnt[k];
    end
    if (do_req && !push_ok) begin
      if (req_high) begin
        cnt_next[CNT_HIGH_REFUSED] = sat_add(cnt[CNT_HIGH_REFUSED], TIME_W'(1));
      end else begin
        cnt_next[CNT_LOW_REFUSED] = sat_add(cnt[CNT_LOW_REFUSED], TIME_W'(1));
      end
    end
    if (idle_tick) begin
      cnt_next[CNT_IDLE_TICKS] = sat_add(cnt[CNT_IDLE_TICKS], TIME_W'(1));
    end
    if (state == ST_FETCH) begin
      if (sel_high) begin
        cnt_next[CNT_HIGH_SERVED] = sat_add(cnt[CNT_HIGH_SERVED], TIME_W'(1));
        cnt_next[CNT_HIGH_WAIT]   = sat_add(cnt[CNT_HIGH_WAIT], srv_wait);
      end else begin
        cnt_next[CNT_LOW_SERVED] = sat_add(cnt[CNT_LOW_SERVED], TIME_W'(1));
        cnt_next[CNT_LOW_WAIT]   = sat_add(cnt[CNT_LOW_WAIT], srv_wait);
      end
    end
  end

  // result of this step
  logic [OUTCOME_W-1:0] outcome_next;
  logic [ID_W-1:0]      served_next;
  logic [TIME_W-1:0]    wait_next;

  always_comb begin
    outcome_next = OUT_IDLE;
    served_next  = '0;
    wait_next    = '0;
    if (state == ST_FETCH) begin
      outcome_next = sel_high ? OUT_SERVED_HIGH : OUT_SERVED_LOW;
      served_next  = srv_id;
      wait_next    = srv_wait;
    end else if (do_req) begin
      outcome_next = push_ok ? OUT_ACCEPTED : OUT_REFUSED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      hhead  <= '0;
      htail  <= '0;
      lhead  <= '0;
      ltail  <= '0;
      hcount <= '0;
      lcount <= '0;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt[k] <= '0;
      end
    end else begin
      state  <= state_next;
      hcount <= hcount_next;
      lcount <= lcount_next;
      for (int k = 0; k < CNT_NUM; k++) begin
        cnt[k] <= cnt_next[k];
      end
      if (hwe) htail <= (htail == LAST_PTR) ? '0 : htail + 1'b1;
      if (lwe) ltail <= (ltail == LAST_PTR) ? '0 : ltail + 1'b1;
      if (hre) hhead <= (hhead == LAST_PTR) ? '0 : hhead + 1'b1;
      if (lre) lhead <= (lhead == LAST_PTR) ? '0 : lhead + 1'b1;
    end
  end

  // tick context for the fetch cycle
  always_ff @(posedge clk) begin
    if (pop_start) begin
      sel_high <= (hcount != '0);
      now_q    <= in_now;
    end
  end

  // result stage, then output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && out_free) begin
        res_valid <= 1'b0;
      end
      if (res_valid && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_user <= outcome_next;
      res_data <= {cnt_next[CNT_LOW_WAIT], cnt_next[CNT_HIGH_WAIT],
                   cnt_next[CNT_IDLE_TICKS], cnt_next[CNT_LOW_SERVED],
                   cnt_next[CNT_HIGH_SERVED], cnt_next[CNT_LOW_REFUSED],
                   cnt_next[CNT_HIGH_REFUSED], lcount_next, hcount_next,
                   wait_next, served_next};
    end
    if (res_valid && out_free) begin
      m_tuser <= res_user;
      m_tdata <= OUT_W'(res_data);
    end
  end

endmodule

// ===== src/tqps_checker.sv =====
// ----------------------------------------------------------------------------
// tqps_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tqps_checker #(
  parameter int QUEUE_DEPTH = tqps_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int CW    = $clog2(QUEUE_DEPTH + 1),
  parameter int OUT_W = ((2 * tqps_pkg::TIME_W + 2 * CW
                          + tqps_pkg::CNT_NUM * tqps_pkg::CNT_W + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [OUT_W-1:0]               m_tdata,
  input logic [tqps_pkg::OUTCOME_W-1:0] m_tuser
);

  import tqps_pkg::*;

  logic [CW-1:0] hocc, locc;

  assign hocc = m_tdata[2*TIME_W+CW-1:2*TIME_W];
  assign locc = m_tdata[2*TIME_W+2*CW-1:2*TIME_W+CW];

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // outcome codes stay within the defined set
  a_outcome: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= OUT_IDLE)
    else $error("undefined outcome code");

  // only a served tick carries an id and a wait
  a_no_serve: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == OUT_ACCEPTED || m_tuser == OUT_REFUSED ||
                 m_tuser == OUT_IDLE) |-> m_tdata[2*TIME_W-1:0] == '0)
    else $error("served fields set on a non-serving outcome");

  // occupancies never pass the queue depth
  a_occ: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> hocc <= CW'(QUEUE_DEPTH) && locc <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // serving from the low queue means the high queue was empty
  a_prio: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == OUT_SERVED_LOW |-> hocc == '0)
    else $error("low queue served while high queue held entries");

endmodule

bind two_queue_priority_scheduler tqps_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .CW          (CW),
  .OUT_W       (OUT_W)
) u_tqps_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
